// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// ASSERT_RST checks a property on the rising clock edge outside reset.
// ASSERT_ALL checks a property on every rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/odpn_pkg.sv =====
package odpn_pkg;

  // Field widths of the channels.
  localparam int OFF_W  = 32;
  localparam int PNUM_W = 7;
  localparam int DCNT_W = 8;
  localparam int MAXP_W = 8;

  // Limit register value after reset.
  localparam logic [MAXP_W-1:0] MAXP_RESET = 8'd64;

  // Default number of cells in the chain.
  localparam int MAX_POSITIONS_DEF = 128;

  // Control flags that travel with a lookup along the chain.
  typedef struct packed {
    logic vld;     // a lookup occupies this stage
    logic start;   // lookup empties the table as it passes
    logic last;    // final position of the table
    logic hit;     // offset found in an earlier cell
    logic stored;  // offset written into an earlier cell
  } qflags_t;

endpackage

// ===== sv/odpn_if.sv =====
// Position channel.
interface odpn_in_if;
  logic                        valid;
  logic                        ready;
  logic [odpn_pkg::OFF_W-1:0]  pattern_offset;
  logic                        start_table;
  logic                        last_position;

  modport source (output valid, output pattern_offset, output start_table,
                  output last_position, input ready);
  modport sink (input valid, input pattern_offset, input start_table,
                input last_position, output ready);
endinterface

// Result channel.
interface odpn_out_if;
  logic                        valid;
  logic                        ready;
  logic [odpn_pkg::PNUM_W-1:0] pattern_number;
  logic                        is_new;
  logic [odpn_pkg::DCNT_W-1:0] distinct_count;
  logic                        over_limit;
  logic                        overflow;
  logic                        done_res;

  modport source (output valid, output pattern_number, output is_new,
                  output distinct_count, output over_limit, output overflow,
                  output done_res, input ready);
  modport sink (input valid, input pattern_number, input is_new,
                input distinct_count, input over_limit, input overflow,
                input done_res, output ready);
endinterface

// Limit register write channel.
interface odpn_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [odpn_pkg::MAXP_W-1:0] max_patterns;

  modport source (output valid, output max_patterns, input ready);
  modport sink (input valid, input max_patterns, output ready);
endinterface

// ===== sv/odpn_cell.sv =====
`include "assert_macros.svh"

module odpn_cell #(
  parameter int IDX   = 0,
  parameter int NUM_W = 7,
  parameter int CNT_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  odpn_pkg::qflags_t           q_in,
  input  logic [odpn_pkg::OFF_W-1:0]  off_in,
  input  logic [NUM_W-1:0]            num_in,
  input  logic [CNT_W-1:0]            cnt_in,
  output odpn_pkg::qflags_t           q_out,
  output logic [odpn_pkg::OFF_W-1:0]  off_out,
  output logic [NUM_W-1:0]            num_out,
  output logic [CNT_W-1:0]            cnt_out
);
  import odpn_pkg::*;

  logic              val_r, val_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  qflags_t           q_r, q_nxt;
  logic [OFF_W-1:0]  qoff_r;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              found, eff_valid, match, store;

  // Compare the passing lookup with the held offset, or claim this slot
  // when it is the first free one and no earlier cell has taken the offset.
  always_comb begin
    found     = q_in.hit | q_in.stored;
    eff_valid = val_r & ~q_in.start;
    match     = q_in.vld & eff_valid & ~found & (off_r == off_in);
    store     = q_in.vld & ~eff_valid & ~found;

    val_nxt = q_in.vld ? (eff_valid | store) : val_r;
    off_nxt = store ? off_in : off_r;

    q_nxt        = q_in;
    q_nxt.hit    = q_in.hit | match;
    q_nxt.stored = q_in.stored | store;

    num_nxt = (match | store) ? NUM_W'(IDX) : num_in;
    cnt_nxt = cnt_in + CNT_W'(eff_valid | store);
  end

  // Control state: slot occupancy and the stage's valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
      q_r   <= '0;
    end else if (adv) begin
      val_r <= val_nxt;
      q_r   <= q_nxt;
    end
  end

  // Held offset and the lookup payload handed to the next cell.
  always_ff @(posedge clk) begin
    if (adv) begin
      off_r  <= off_nxt;
      qoff_r <= off_in;
      num_r  <= num_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign q_out   = q_r;
  assign off_out = qoff_r;
  assign num_out = num_r;
  assign cnt_out = cnt_r;

  // A table start that was claimed upstream leaves this slot empty.
  `ASSERT_RST(a_start_clears, clk, rst_n, adv && q_in.vld && q_in.start && found |=> !val_r, "odpn_cell: start did not empty slot")
  // A slot that takes a new offset holds it afterwards.
  `ASSERT_RST(a_store_holds, clk, rst_n, adv && store |=> val_r && (off_r == $past(off_in)), "odpn_cell: stored offset lost")

endmodule

// ===== sv/offset_dedup_pattern_numbering_unit.sv =====
// Pattern numbering by offset deduplication.
//
// in_ch carries one song position per transfer: a 32-bit pattern offset,
// a start flag that empties the table and a last-position flag. out_ch
// returns one result per position, in order: the pattern number, whether
// the offset is new, the distinct count so far, the limit flag, the
// overflow flag and a copy of the last-position flag. cfg_ch writes the
// pattern limit; it is always ready and should be written while idle.
//
// The lookup walks a chain of MAX_POSITIONS cells, one cell per cycle while
// out_ch does not stall, and each occupied cell holds one distinct offset. A
// position may enter every cycle unless out_ch stalls, so throughput is then
// one item per cycle. The first cell registers the position at the transfer,
// each further cell registers it in turn, and the output register then holds
// the result that appears on out_ch.
// Reset empties the table and sets the limit to 64; no clearing pass is
// needed. When the receiver stalls, the whole chain holds and in_ch drops
// ready until the waiting result is taken.
`include "assert_macros.svh"

module offset_dedup_pattern_numbering_unit #(
  parameter int MAX_POSITIONS = odpn_pkg::MAX_POSITIONS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  odpn_in_if.sink      in_ch,
  odpn_out_if.source   out_ch,
  odpn_cfg_if.sink     cfg_ch
);
  import odpn_pkg::*;

  localparam int NUM_W = $clog2(MAX_POSITIONS);
  localparam int CNT_W = $clog2(MAX_POSITIONS + 1);
  localparam int CMP_W = (CNT_W > MAXP_W) ? CNT_W : MAXP_W;

  // Links between the cells; index 0 is the chain input.
  qflags_t           q_lnk   [MAX_POSITIONS+1];
  logic [OFF_W-1:0]  off_lnk [MAX_POSITIONS+1];
  logic [NUM_W-1:0]  num_lnk [MAX_POSITIONS+1];
  logic [CNT_W-1:0]  cnt_lnk [MAX_POSITIONS+1];

  logic              adv;
  logic [MAXP_W-1:0] max_r;
  logic              out_valid_r;
  logic [PNUM_W-1:0] num_r;
  logic              is_new_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              over_r;
  logic              ovf_r;
  logic              done_r;
  qflags_t           tail_q;

  // The chain moves whenever the output register is free or being emptied.
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Fresh lookup entering the first cell.
  always_comb begin
    q_lnk[0]        = '0;
    q_lnk[0].vld    = in_ch.valid;
    q_lnk[0].start  = in_ch.start_table;
    q_lnk[0].last   = in_ch.last_position;
    off_lnk[0]      = in_ch.pattern_offset;
    num_lnk[0]      = '0;
    cnt_lnk[0]      = '0;
  end

  // Row of cells, one per table slot.
  for (genvar i = 0; i < MAX_POSITIONS; i++) begin : g_cell
    odpn_cell #(
      .IDX   (i),
      .NUM_W (NUM_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .q_in    (q_lnk[i]),
      .off_in  (off_lnk[i]),
      .num_in  (num_lnk[i]),
      .cnt_in  (cnt_lnk[i]),
      .q_out   (q_lnk[i+1]),
      .off_out (off_lnk[i+1]),
      .num_out (num_lnk[i+1]),
      .cnt_out (cnt_lnk[i+1])
    );
  end

  assign tail_q = q_lnk[MAX_POSITIONS];

  // Limit register.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAXP_RESET;
    end else if (cfg_ch.valid) begin
      max_r <= cfg_ch.max_patterns;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail_q.vld;
    end
  end

  // Output register payload, taken from the end of the chain.
  always_ff @(posedge clk) begin
    if (adv) begin
      num_r    <= PNUM_W'(num_lnk[MAX_POSITIONS]);
      is_new_r <= ~tail_q.hit;
      cnt_r    <= cnt_lnk[MAX_POSITIONS];
      over_r   <= CMP_W'(cnt_lnk[MAX_POSITIONS]) > CMP_W'(max_r);
      ovf_r    <= ~tail_q.hit & ~tail_q.stored;
      done_r   <= tail_q.last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pattern_number = num_r;
  assign out_ch.is_new         = is_new_r;
  assign out_ch.distinct_count = DCNT_W'(cnt_r);
  assign out_ch.over_limit     = over_r;
  assign out_ch.overflow       = ovf_r;
  assign out_ch.done_res       = done_r;

  // A lookup leaving the chain lands in the output register.
  `ASSERT_RST(a_tail_to_out, clk, rst_n, adv && tail_q.vld |=> out_valid_r, "odpn: result dropped at chain end")
  // Every result sees at least one stored offset in the table.
  `ASSERT_RST(a_count_nonzero, clk, rst_n, out_valid_r |-> cnt_r != '0, "odpn: result with empty table")

endmodule
